FILE: design/irc_pkg.sv
// shared types, constants and the digit alphabet for the integer radix converter
package irc_pkg;

  // base registers and their limits
  localparam int BASE_W = 7;
  localparam int REM_W  = 6;
  localparam logic [BASE_W-1:0] BASE_MIN     = 7'd2;
  localparam logic [BASE_W-1:0] BASE_MAX     = 7'd64;
  localparam logic [BASE_W-1:0] BASE_DEC     = 7'd10;
  localparam logic [BASE_W-1:0] BASE_SYM_MIN = 7'd11;
  localparam logic [BASE_W-1:0] BASE_RESET   = 7'd10;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = 2'd1;

  // ascii code points of the alphabet segments
  localparam int SYM_W = 7;
  localparam logic [SYM_W-1:0] CH_ZERO    = 7'd48;
  localparam logic [SYM_W-1:0] CH_UPPER_A = 7'd65;
  localparam logic [SYM_W-1:0] CH_LOWER_A = 7'd97;
  localparam logic [SYM_W-1:0] CH_PLUS    = 7'd43;
  localparam logic [SYM_W-1:0] CH_SLASH   = 7'd47;
  localparam logic [REM_W-1:0] DIG_UPPER  = 6'd10;
  localparam logic [REM_W-1:0] DIG_LOWER  = 6'd36;
  localparam logic [REM_W-1:0] DIG_PLUS   = 6'd62;

  // command queue between front and back (depth is a power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // classified command carried with each number
  typedef struct packed {
    logic                reint;
    logic [BASE_W-1:0]   div_base;
    logic [BASE_W-1:0]   mul_base;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_DIGIT,
    B_MUL,
    B_ACC,
    B_EMIT,
    B_RESULT
  } back_state_t;

  // clamp a base register into 2..64
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] c;
    if (b < BASE_MIN) begin
      c = BASE_MIN;
    end else if (b > BASE_MAX) begin
      c = BASE_MAX;
    end else begin
      c = b;
    end
    return c;
  endfunction

  // character of a digit 0..63: 0-9, A-Z, a-z, +, /
  function automatic logic [SYM_W-1:0] glyph(input logic [REM_W-1:0] d);
    logic [SYM_W-1:0] dx;
    logic [SYM_W-1:0] c;
    dx = {1'b0, d};
    if (d < DIG_UPPER) begin
      c = CH_ZERO + dx;
    end else if (d < DIG_LOWER) begin
      c = CH_UPPER_A + dx - {1'b0, DIG_UPPER};
    end else if (d < DIG_PLUS) begin
      c = CH_LOWER_A + dx - {1'b0, DIG_LOWER};
    end else if (d == DIG_PLUS) begin
      c = CH_PLUS;
    end else begin
      c = CH_SLASH;
    end
    return c;
  endfunction

endpackage

FILE: design/irc_front.sv
// front end: base registers, item intake and mode classification
module irc_front import irc_pkg::*; #(
  parameter int NUMBER_WIDTH = 31
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] number,
  output logic                    busy,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [BASE_W-1:0]       cfg_data,
  input  logic                    q_full,
  output logic                    push,
  output cmd_t                    push_cmd,
  output logic [NUMBER_WIDTH-1:0] push_number
);

  logic [BASE_W-1:0] source_base;
  logic [BASE_W-1:0] target_base;
  logic [BASE_W-1:0] sb_eff;
  logic [BASE_W-1:0] tb_eff;
  logic              reint;

  // configuration writes, unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_base <= BASE_RESET;
      target_base <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_BASE: source_base <= cfg_data;
        REG_TARGET_BASE: target_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify: decimal digits reread in the source base, or digit conversion
  always_comb begin
    sb_eff = clamp_base(source_base);
    tb_eff = clamp_base(target_base);
    reint  = (sb_eff != BASE_DEC) && (tb_eff == BASE_DEC);
    push_cmd.reint    = reint;
    push_cmd.div_base = reint ? BASE_DEC : tb_eff;
    push_cmd.mul_base = sb_eff;
  end

  // intake beat
  assign busy        = q_full;
  assign push        = start && !q_full;
  assign push_number = number;

endmodule

FILE: design/irc_queue.sv
// short command queue between front and back
module irc_queue import irc_pkg::*; #(
  parameter int WIDTH = 46
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0]  slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full    = (fill == QCNT_W'(QDEPTH));
  assign valid   = (fill != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: design/irc_back.sv
// back end: shared bit-serial divider, digit stack, reread accumulator, result beats
module irc_back import irc_pkg::*; #(
  parameter int NUMBER_WIDTH = 31,
  parameter int MAX_DIGITS   = 31
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  logic [NUMBER_WIDTH-1:0] q_number,
  input  cmd_t                    q_cmd,
  output logic                    q_pop,
  output logic                    result_valid,
  output logic [NUMBER_WIDTH-1:0] digit_value,
  output logic [SYM_W-1:0]        symbol,
  output logic                    is_symbol,
  output logic                    overflow,
  output logic                    last
);

  localparam int NW   = NUMBER_WIDTH;
  localparam int PRW  = NW + 4;
  localparam int SUMW = NW + 5;
  localparam int PNW  = NW + BASE_W;
  localparam int DCW  = $clog2(NW);
  localparam int CW   = $clog2(MAX_DIGITS + 1);
  localparam int IW   = $clog2(MAX_DIGITS);

  back_state_t state, state_next;

  logic [NW-1:0]     n;
  logic [REM_W-1:0]  r;
  logic [DCW-1:0]    bcnt;
  logic [BASE_W-1:0] divisor;
  logic [BASE_W-1:0] mul_base;
  logic              reint;
  logic [CW-1:0]     count;
  logic [CW-1:0]     emit_idx;
  logic [NW-1:0]     acc;
  logic [NW-1:0]     pw;
  logic              pw_big;
  logic              ovf;
  logic [3:0]        dig;
  logic [PRW-1:0]    prod;
  logic [PNW-1:0]    pwn;
  logic [REM_W-1:0]  stack [MAX_DIGITS];

  logic [BASE_W-1:0] div_try;
  logic [BASE_W-1:0] div_sub;
  logic              div_ge;
  logic [REM_W-1:0]  r_step;
  logic [NW-1:0]     n_step;
  logic [SUMW-1:0]   sum;
  logic              sum_over;
  logic              pwn_over;
  logic              ovf_now;
  logic [CW-1:0]     count_inc;
  logic              conv_done;

  // one restoring divide step per cycle
  always_comb begin
    div_try = {r, n[NW-1]};
    div_ge  = (div_try >= divisor);
    div_sub = div_try - divisor;
    r_step  = div_ge ? div_sub[REM_W-1:0] : div_try[REM_W-1:0];
    n_step  = {n[NW-2:0], div_ge};
  end

  // accumulate and power checks for the reread mode
  always_comb begin
    sum       = SUMW'(acc) + SUMW'(prod);
    sum_over  = (sum[SUMW-1:NW] != '0);
    pwn_over  = (pwn[PNW-1:NW] != '0);
    ovf_now   = (dig != 4'd0) && (pw_big || sum_over);
    count_inc = count + CW'(1);
    conv_done = (n == '0) || (count_inc == CW'(MAX_DIGITS));
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and queue pop
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.reint && (q_number == '0)) begin
            state_next = B_RESULT;
          end else begin
            state_next = B_DIV;
          end
        end
      end
      B_DIV: begin
        if (bcnt == '0) begin
          state_next = B_DIGIT;
        end
      end
      B_DIGIT: begin
        if (reint) begin
          state_next = B_MUL;
        end else if (conv_done) begin
          state_next = B_EMIT;
        end else begin
          state_next = B_DIV;
        end
      end
      B_MUL: state_next = B_ACC;
      B_ACC: begin
        if (ovf_now || (n == '0)) begin
          state_next = B_RESULT;
        end else begin
          state_next = B_DIV;
        end
      end
      B_EMIT: begin
        if (emit_idx == '0) begin
          state_next = B_IDLE;
        end
      end
      B_RESULT: state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // digit count and emit index
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      emit_idx <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            count <= '0;
          end
        end
        B_DIGIT: begin
          if (!reint) begin
            count    <= count_inc;
            emit_idx <= count;
          end
        end
        B_EMIT: emit_idx <= emit_idx - CW'(1);
        default: ;
      endcase
    end
  end

  // divider, accumulator and power registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          n        <= q_number;
          r        <= '0;
          bcnt     <= DCW'(NW - 1);
          divisor  <= q_cmd.div_base;
          mul_base <= q_cmd.mul_base;
          reint    <= q_cmd.reint;
          acc      <= '0;
          pw       <= NW'(1);
          pw_big   <= 1'b0;
          ovf      <= 1'b0;
        end
      end
      B_DIV: begin
        n    <= n_step;
        r    <= r_step;
        bcnt <= bcnt - DCW'(1);
      end
      B_DIGIT: begin
        dig  <= r[3:0];
        r    <= '0;
        bcnt <= DCW'(NW - 1);
      end
      B_MUL: begin
        prod <= PRW'(dig) * PRW'(pw);
        pwn  <= PNW'(pw) * PNW'(mul_base);
      end
      B_ACC: begin
        ovf <= ovf_now;
        if ((dig != 4'd0) && !ovf_now) begin
          acc <= sum[NW-1:0];
        end
        if (!pw_big) begin
          if (pwn_over) begin
            pw_big <= 1'b1;
          end else begin
            pw <= pwn[NW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // digit stack, least significant digit first
  always_ff @(posedge clk) begin
    if ((state == B_DIGIT) && !reint) begin
      stack[count[IW-1:0]] <= r;
    end
  end

  // result beat strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == B_EMIT) || (state == B_RESULT);
    end
  end

  // result beat payload, digits read back most significant first
  always_ff @(posedge clk) begin
    if (state == B_EMIT) begin
      digit_value <= NW'(stack[emit_idx[IW-1:0]]);
      is_symbol   <= (divisor >= BASE_SYM_MIN);
      symbol      <= (divisor >= BASE_SYM_MIN) ? glyph(stack[emit_idx[IW-1:0]]) : '0;
      overflow    <= 1'b0;
      last        <= (emit_idx == '0);
    end else if (state == B_RESULT) begin
      digit_value <= ovf ? '1 : acc;
      is_symbol   <= 1'b0;
      symbol      <= '0;
      overflow    <= ovf;
      last        <= 1'b1;
    end
  end

endmodule

FILE: design/integer_radix_conversion_top.sv
// integer radix converter top level: front, command queue and back end
//
//  channel   signals                                   handshake
//  input     start, busy, number                       taken when start and not busy
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data taken when valid and ready
//  result    result_valid, digit_value, symbol,        one beat per cycle with strobe
//            is_symbol, overflow, last
//
// digit conversion: the shared bit-serial divider produces each output digit,
// then the result beats are read from the digit stack.
// decimal reread: each decimal digit of the input goes through the shared
// divider (divide by ten, multiply, accumulate), then one result beat.
// the two-entry command queue takes items while the back end is working.
// synchronous reset clears the bases to ten and empties the queue.
// results cannot be held off; busy rises only when the queue is full.
module integer_radix_conversion_top import irc_pkg::*; #(
  parameter int NUMBER_WIDTH = 31,
  parameter int MAX_DIGITS   = 31
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [NUMBER_WIDTH-1:0] number,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [BASE_W-1:0]       cfg_data,
  output logic                    result_valid,
  output logic [NUMBER_WIDTH-1:0] digit_value,
  output logic [SYM_W-1:0]        symbol,
  output logic                    is_symbol,
  output logic                    overflow,
  output logic                    last
);

  localparam int CMDW = $bits(cmd_t);
  localparam int QW   = NUMBER_WIDTH + CMDW;

  logic                    q_full;
  logic                    q_valid;
  logic                    push;
  logic                    pop;
  cmd_t                    push_cmd;
  logic [NUMBER_WIDTH-1:0] push_number;
  logic [QW-1:0]           q_head;
  cmd_t                    q_cmd;
  logic [NUMBER_WIDTH-1:0] q_number;

  // intake and classification
  irc_front #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .number     (number),
    .busy       (busy),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_number(push_number)
  );

  // command queue
  irc_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({push_number, push_cmd}),
    .pop      (pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  assign q_number = q_head[QW-1:CMDW];
  assign q_cmd    = cmd_t'(q_head[CMDW-1:0]);

  // conversion engine
  irc_back #(
    .NUMBER_WIDTH(NUMBER_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_number    (q_number),
    .q_cmd       (q_cmd),
    .q_pop       (pop),
    .result_valid(result_valid),
    .digit_value (digit_value),
    .symbol      (symbol),
    .is_symbol   (is_symbol),
    .overflow    (overflow),
    .last        (last)
  );

endmodule
